### rtl/urc_pkg.sv
// Shared types, constants and helpers for the ultrasonic range controller.
// No dependencies; imported by urc_cfg, urc_dist, urc_core and the top level.
package urc_pkg;

  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int CMP_W = (COUNT_BITS > 20) ? COUNT_BITS : 20;

  localparam int STATUS_W = 3;
  localparam int ETIME_W  = 16;
  localparam int DIST_W   = 14;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  // floor(x / 100) as (x * RECIP) >> RECIP_SHIFT, exact for x below 2^27 / 72
  localparam int DIST_X_W    = 21;
  localparam int RECIP_SHIFT = 27;
  localparam logic [20:0] RECIP = 21'd1342178;

  typedef enum logic [2:0] {
    PH_STARTUP   = 3'd0,
    PH_TRIGGER   = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_TIME_HIGH = 3'd3,
    PH_PAUSE     = 3'd4
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 3'd0,
    ST_DIST    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_NOECHO  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STARTUP_DELAY = 3'd0,
    CFG_TRIGGER_WIDTH = 3'd1,
    CFG_ECHO_START_TO = 3'd2,
    CFG_ECHO_END_TO   = 3'd3,
    CFG_MAX_RANGE     = 3'd4,
    CFG_PERIOD        = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] startup_delay_us;
    logic [7:0]  trigger_width_us;
    logic [15:0] echo_start_timeout_us;
    logic [15:0] echo_end_timeout_us;
    logic [15:0] max_range_us;
    logic [19:0] period_us;
  } urc_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance_tenth_cm;
    logic [ETIME_W-1:0] echo_time_us;
    status_e            status;
    logic               trigger_level;
  } urc_result_t;

  // limit a 20-bit delay to what the tick counter can reach
  function automatic logic [COUNT_BITS-1:0] cap_count(input logic [19:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve > CMP_W'(CNT_MAX)) return CNT_MAX;
    else return COUNT_BITS'(ve);
  endfunction

  function automatic logic [ETIME_W-1:0] sat_etime(input logic [COUNT_BITS-1:0] c);
    if (c > COUNT_BITS'({ETIME_W{1'b1}})) return {ETIME_W{1'b1}};
    else return c[ETIME_W-1:0];
  endfunction

endpackage

### rtl/urc_cfg.sv
// Configuration register file of the range controller.
// Depends on urc_pkg for the register index codes and the config struct.
module urc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output urc_pkg::urc_cfg_t             cfg_o
);
  import urc_pkg::*;

  urc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STARTUP_DELAY: cfg_d.startup_delay_us      = cfg_data_i[19:0];
        CFG_TRIGGER_WIDTH: cfg_d.trigger_width_us      = cfg_data_i[7:0];
        CFG_ECHO_START_TO: cfg_d.echo_start_timeout_us = cfg_data_i[15:0];
        CFG_ECHO_END_TO:   cfg_d.echo_end_timeout_us   = cfg_data_i[15:0];
        CFG_MAX_RANGE:     cfg_d.max_range_us          = cfg_data_i[15:0];
        CFG_PERIOD:        cfg_d.period_us             = cfg_data_i[19:0];
        default:           cfg_d = cfg_q; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_delay_us      <= 20'd500000;
      cfg_q.trigger_width_us      <= 8'd10;
      cfg_q.echo_start_timeout_us <= 16'd5000;
      cfg_q.echo_end_timeout_us   <= 16'd60000;
      cfg_q.max_range_us          <= 16'd38000;
      cfg_q.period_us             <= 20'd1000000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/urc_dist.sv
// Echo time to distance in tenths of a centimetre: (t*17 + 50) / 100.
// Depends on urc_pkg; the divide by 100 is a reciprocal multiply.
module urc_dist (
  input  logic [urc_pkg::ETIME_W-1:0] etime_i,
  output logic [urc_pkg::DIST_W-1:0]  dist_o
);
  import urc_pkg::*;

  logic [DIST_X_W-1:0]            x;
  logic [DIST_X_W+21-1:0]         prod;

  // t*17 = t*16 + t
  assign x    = (DIST_X_W'(etime_i) << 4) + DIST_X_W'(etime_i) + DIST_X_W'(50);
  assign prod = (DIST_X_W+21)'(x) * (DIST_X_W+21)'(RECIP);
  assign dist_o = prod[RECIP_SHIFT +: DIST_W];

endmodule

### rtl/urc_core.sv
// Measurement sequencer: phase and tick counter, one step per accepted beat.
// Depends on urc_pkg and urc_dist.
module urc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 echo_i,
  input  urc_pkg::urc_cfg_t    cfg_i,
  output urc_pkg::urc_result_t res_o
);
  import urc_pkg::*;

  phase_e                phase_q, phase_d, ph;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt, bumped;
  logic [ETIME_W-1:0]    etime_fall;
  logic [DIST_W-1:0]     dist_fall;

  assign etime_fall = sat_etime(cnt);

  urc_dist u_dist (
    .etime_i (etime_fall),
    .dist_o  (dist_fall)
  );

  always_comb begin
    ph  = phase_q;
    cnt = cnt_q;
    if (phase_q > PH_PAUSE) begin
      ph  = PH_STARTUP;
      cnt = '0;
    end
    if (ph == PH_STARTUP && cnt >= cap_count(cfg_i.startup_delay_us)) begin
      ph  = PH_TRIGGER;
      cnt = '0;
    end
    if (ph == PH_PAUSE && cnt >= cap_count(cfg_i.period_us)) begin
      ph  = PH_TRIGGER;
      cnt = '0;
    end
    bumped = (cnt < CNT_MAX) ? cnt + COUNT_BITS'(1) : cnt;

    phase_d = ph;
    cnt_d   = cnt;
    res_o   = '{distance_tenth_cm: '0, echo_time_us: '0, status: ST_NONE,
                trigger_level: 1'b0};

    unique case (ph)
      PH_STARTUP, PH_PAUSE: begin
        cnt_d = bumped;
      end
      PH_TRIGGER: begin
        res_o.trigger_level = 1'b1;
        cnt_d = bumped;
        // zero width still gives one high tick
        if (bumped >= COUNT_BITS'(cfg_i.trigger_width_us)) begin
          phase_d = PH_WAIT_RISE;
          cnt_d   = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_i) begin
          phase_d = PH_TIME_HIGH;
          cnt_d   = COUNT_BITS'(1);
        end else begin
          cnt_d = bumped;
          if (bumped > COUNT_BITS'(cfg_i.echo_start_timeout_us)) begin
            res_o.status = ST_NOECHO;
            phase_d = PH_PAUSE;
            cnt_d   = '0;
          end
        end
      end
      PH_TIME_HIGH: begin
        if (!echo_i) begin
          res_o.echo_time_us = etime_fall;
          if (etime_fall > cfg_i.max_range_us) begin
            res_o.status = ST_RANGE;
          end else begin
            res_o.status = ST_DIST;
            res_o.distance_tenth_cm = dist_fall;
          end
          phase_d = PH_PAUSE;
          cnt_d   = '0;
        end else begin
          cnt_d = bumped;
          if (bumped > COUNT_BITS'(cfg_i.echo_end_timeout_us)) begin
            res_o.status       = ST_TIMEOUT;
            res_o.echo_time_us = sat_etime(bumped);
            phase_d = PH_PAUSE;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        phase_d = PH_STARTUP;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STARTUP;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/ultrasonic_range_controller.sv
// Ultrasonic range controller top level: input beat register, sequencer, result register.
// A beat accepted on s_axis goes through the input beat register, the sequencer and the result register to m_axis.
// Throughput: one beat per cycle while m_axis_tready is high; the single input and result registers bound it.
// Reset (rst_ni low, asynchronous): both registers empty, start-up phase, counter zero,
// configuration back to its default values.
module ultrasonic_range_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [urc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] echo_level
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] trigger_level, [3:1] status, [19:4] echo_time_us, [33:20] distance_tenth_cm
  output logic [urc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [urc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import urc_pkg::*;

  urc_cfg_t    cfg;
  urc_result_t res;
  urc_result_t res_q;
  logic        in_v_q, out_v_q, echo_q, advance, step;

  assign cfg_ready_o = 1'b1;

  urc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result register free or being drained this cycle
  assign advance       = !out_v_q || m_axis_tready;
  assign step          = in_v_q && advance;
  assign s_axis_tready = !in_v_q || advance;

  urc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .echo_i (echo_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (advance) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) echo_q <= s_axis_tdata[0];
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, res_q.distance_tenth_cm, res_q.echo_time_us,
                          res_q.status, res_q.trigger_level};

endmodule

### rtl/urc_checker.sv
// Port-level checks for the ultrasonic range controller, bound to the top level.
// Depends on the top level's ports only.
module urc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [2:0]  st;
  logic [15:0] et;
  logic [13:0] tenths;
  logic        trig;

  assign trig   = m_axis_tdata[0];
  assign st     = m_axis_tdata[3:1];
  assign et     = m_axis_tdata[19:4];
  assign tenths = m_axis_tdata[33:20];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // trigger is only driven on ticks that report nothing
  a_trig_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trig |-> st == 3'd0 && et == 16'd0)
    else $error("trigger high on a reporting tick");

  // no report or no echo carries no time and no distance
  a_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == 3'd0 || st == 3'd4) |-> et == 16'd0 && tenths == 14'd0)
    else $error("time or distance without a measurement");

  // distance within what a 16-bit echo time can give
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> st <= 3'd4 && tenths <= 14'd11141 &&
                      (st == 3'd1 || tenths == 14'd0))
    else $error("distance out of bounds");

endmodule

bind ultrasonic_range_controller urc_checker u_urc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/tb.sv
// Self-checking bench for ultrasonic_range_controller: echo samples in, one reading per beat.
// Needs rtl/urc_pkg.sv, urc_cfg, urc_dist, urc_core and the top level; prediction is built in here.
module tb;
  import urc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_BEATS = 850;
  localparam int PHASE_BEATS = 200;
  // indexes past the register file, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ultrasonic_range_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ranging state mirrored by the bench
  urc_cfg_t rg_cfg;
  phase_e rg_phase;
  logic [COUNT_BITS-1:0] rg_ticks;

  bit echo_pending[$];
  urc_result_t ranging_due[$];

  int mismatches = 0;
  int readings = 0;
  int beats_sent = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int status_seen[8];
  urc_result_t got_rd, want_rd;

  function automatic void tick_up();
    if (rg_ticks < CNT_MAX) rg_ticks = rg_ticks + COUNT_BITS'(1);
  endfunction

  function automatic logic [ETIME_W-1:0] clip16(input logic [COUNT_BITS-1:0] c);
    return (c > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : c[ETIME_W-1:0];
  endfunction

  // one microsecond tick of the ranging sequencer
  function automatic urc_result_t ranging_step(input logic echo);
    urc_result_t r;
    int unsigned scaled;
    r = '0;
    r.status = ST_NONE;
    if (rg_phase == PH_STARTUP && rg_ticks >= rg_cfg.startup_delay_us) begin
      rg_phase = PH_TRIGGER;
      rg_ticks = '0;
    end
    if (rg_phase == PH_PAUSE && rg_ticks >= rg_cfg.period_us) begin
      rg_phase = PH_TRIGGER;
      rg_ticks = '0;
    end
    case (rg_phase)
      PH_STARTUP, PH_PAUSE: tick_up();
      PH_TRIGGER: begin
        r.trigger_level = 1'b1;
        tick_up();
        // a width of zero still gives one trigger tick
        if (rg_ticks >= COUNT_BITS'(rg_cfg.trigger_width_us)) begin
          rg_phase = PH_WAIT_RISE;
          rg_ticks = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          rg_phase = PH_TIME_HIGH;
          rg_ticks = COUNT_BITS'(1);
        end else begin
          tick_up();
          if (rg_ticks > COUNT_BITS'(rg_cfg.echo_start_timeout_us)) begin
            r.status = ST_NOECHO;
            rg_phase = PH_PAUSE;
            rg_ticks = '0;
          end
        end
      end
      default: begin
        if (!echo) begin
          r.echo_time_us = clip16(rg_ticks);
          if (r.echo_time_us > rg_cfg.max_range_us) begin
            r.status = ST_RANGE;
          end else begin
            r.status = ST_DIST;
            // 0.017 cm/us, tenths, rounded
            scaled = 32'(r.echo_time_us) * 32'd17 + 32'd50;
            r.distance_tenth_cm = DIST_W'(scaled / 32'd100);
          end
          rg_phase = PH_PAUSE;
          rg_ticks = '0;
        end else begin
          tick_up();
          if (rg_ticks > COUNT_BITS'(rg_cfg.echo_end_timeout_us)) begin
            r.status = ST_TIMEOUT;
            r.echo_time_us = clip16(rg_ticks);
            rg_phase = PH_PAUSE;
            rg_ticks = '0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // sender: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ranging_due.push_back(ranging_step(s_axis_tdata[0]));
        void'(echo_pending.pop_front());
        beats_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (echo_pending.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, echo_pending[0]};
          burst_left--;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, redrawn now and then, sometimes all-ready
  logic [15:0] stall_pat = '1;
  int pat_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_pat = '1;
      pat_left = 0;
    end else begin
      if (pat_left == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pat_left = $urandom_range(20, 300);
      end else begin
        pat_left--;
      end
      m_axis_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rd = urc_result_t'(m_axis_tdata[$bits(urc_result_t)-1:0]);
      if (ranging_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reading with nothing pending: tdata %h", m_axis_tdata);
      end else begin
        want_rd = ranging_due.pop_front();
        readings++;
        status_seen[want_rd.status]++;
        if (got_rd.trigger_level !== want_rd.trigger_level ||
            got_rd.status !== want_rd.status ||
            got_rd.echo_time_us !== want_rd.echo_time_us ||
            got_rd.distance_tenth_cm !== want_rd.distance_tenth_cm) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"reading %0d: expected trig %0b status %0d time %0d dist %0d,",
                      " got trig %0b status %0d time %0d dist %0d"},
                     readings, want_rd.trigger_level, want_rd.status, want_rd.echo_time_us,
                     want_rd.distance_tenth_cm, got_rd.trigger_level, got_rd.status,
                     got_rd.echo_time_us, got_rd.distance_tenth_cm);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d readings outstanding",
               cycle_count, ranging_due.size());
      $display("ultrasonic_range_controller regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_STARTUP_DELAY: rg_cfg.startup_delay_us = val;
      CFG_TRIGGER_WIDTH: rg_cfg.trigger_width_us = val[7:0];
      CFG_ECHO_START_TO: rg_cfg.echo_start_timeout_us = val[15:0];
      CFG_ECHO_END_TO:   rg_cfg.echo_end_timeout_us = val[15:0];
      CFG_MAX_RANGE:     rg_cfg.max_range_us = val[15:0];
      CFG_PERIOD:        rg_cfg.period_us = val;
      default: ;
    endcase
  endtask

  // wait until every queued beat has gone in and every reading has come back
  task automatic settle();
    while (echo_pending.size() != 0 || ranging_due.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
  endtask

  task automatic queue_burst(input int lead, input int hi);
    repeat (lead) echo_pending.push_back(1'b0);
    repeat (hi) echo_pending.push_back(1'b1);
  endtask

  task automatic shuffle_settings();
    if ($urandom_range(0, 1)) write_reg(CFG_STARTUP_DELAY, 20'($urandom));
    if ($urandom_range(0, 1)) write_reg(CFG_TRIGGER_WIDTH, {12'($urandom), 8'($urandom_range(0, 12))});
    if ($urandom_range(0, 1)) write_reg(CFG_ECHO_START_TO, {4'($urandom), 16'($urandom_range(1, 30))});
    if ($urandom_range(0, 1)) write_reg(CFG_ECHO_END_TO, {4'($urandom), 16'($urandom_range(1, 40))});
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_RANGE, {4'($urandom), 16'($urandom_range(0, 45))});
    if ($urandom_range(0, 1)) write_reg(CFG_PERIOD, 20'($urandom_range(1, 25)));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B, 20'($urandom));
  endtask

  initial begin
    int random_beats;
    int phase_beats;
    int lead;
    int hi;
    int n;
    rg_cfg = '{startup_delay_us: 20'd500000, trigger_width_us: 8'd10,
               echo_start_timeout_us: 16'd5000, echo_end_timeout_us: 16'd60000,
               max_range_us: 16'd38000, period_us: 20'd1000000};
    rg_phase = PH_STARTUP;
    rg_ticks = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short start-up, zero trigger width (upper data bits dropped), tight windows
    write_reg(CFG_STARTUP_DELAY, 20'd3);
    write_reg(CFG_TRIGGER_WIDTH, 20'hABC00);
    write_reg(CFG_ECHO_START_TO, 20'hF0006);
    write_reg(CFG_ECHO_END_TO, 20'd8);
    write_reg(CFG_MAX_RANGE, 20'd3);
    write_reg(CFG_PERIOD, 20'd1);
    write_reg(CFG_IDX_SPARE_A, 20'hFFFFF);
    write_reg(CFG_IDX_SPARE_B, 20'h12345);
    @(negedge clk_i);
    queue_burst(5, 1);
    queue_burst(6, 3);
    queue_burst(6, 4);
    queue_burst(6, 12);
    queue_burst(20, 0);
    settle();

    // widest windows: long echoes measured well inside the timeouts
    write_reg(CFG_TRIGGER_WIDTH, 20'd255);
    write_reg(CFG_ECHO_START_TO, 20'd65535);
    write_reg(CFG_ECHO_END_TO, 20'd65535);
    write_reg(CFG_MAX_RANGE, 20'd65535);
    write_reg(CFG_PERIOD, 20'd3);
    @(negedge clk_i);
    queue_burst(280, 120);
    queue_burst(260, 90);
    queue_burst(2, 0);
    settle();

    // longest pause and start-up settings, left only briefly
    write_reg(CFG_PERIOD, 20'hFFFFF);
    write_reg(CFG_STARTUP_DELAY, 20'hFFFFF);
    @(negedge clk_i);
    repeat (12) echo_pending.push_back(1'($urandom));
    settle();

    // narrowest windows and zero range: every echo that ends in time is out of range, longer ones time out
    write_reg(CFG_STARTUP_DELAY, 20'd0);
    write_reg(CFG_TRIGGER_WIDTH, 20'd1);
    write_reg(CFG_ECHO_START_TO, 20'd1);
    write_reg(CFG_ECHO_END_TO, 20'd1);
    write_reg(CFG_MAX_RANGE, 20'd0);
    write_reg(CFG_PERIOD, 20'd2);
    @(negedge clk_i);
    queue_burst(4, 1);
    queue_burst(4, 2);
    queue_burst(6, 0);
    queue_burst(3, 1);
    queue_burst(3, 0);
    settle();

    // random settings, mostly echo pulses of random length, some noise
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      shuffle_settings();
      @(negedge clk_i);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 10);
          repeat (n) echo_pending.push_back(1'($urandom));
          phase_beats += n;
        end else begin
          lead = $urandom_range(0, int'(rg_cfg.trigger_width_us) + int'(rg_cfg.period_us) +
                                   int'(rg_cfg.echo_start_timeout_us) + 3);
          hi = $urandom_range(1, int'(rg_cfg.echo_end_timeout_us) + 5);
          queue_burst(lead, hi);
          phase_beats += lead + hi;
        end
      end
      random_beats += phase_beats;
      settle();
    end

    repeat (10) @(posedge clk_i);
    $display("%0d echo beats, %0d readings, %0d register writes", beats_sent, readings, reg_writes);
    $display("readings by kind: distance %0d, out of range %0d, echo timeout %0d, no echo %0d",
             status_seen[ST_DIST], status_seen[ST_RANGE], status_seen[ST_TIMEOUT],
             status_seen[ST_NOECHO]);
    if (mismatches == 0 && ranging_due.size() == 0) begin
      $display("ultrasonic_range_controller regression: pass");
    end else begin
      $display("ultrasonic_range_controller regression: fail");
    end
    $finish;
  end

endmodule
